// ===== rtl/stdsd_pkg.sv =====
package stdsd_pkg;

  localparam int OFFSET_W    = 10;
  localparam int SPAN_W      = 10;
  localparam int STEPS_W     = 8;
  localparam int DUTY_W      = 16;
  localparam int DSTEP_W     = 8;
  localparam int ANGLE_W     = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int KIND_W      = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OFFSET_W-1:0] OFFSET_RST    = 10'd400;
  localparam logic [SPAN_W-1:0]   SPAN_RST      = 10'd400;
  localparam logic [STEPS_W-1:0]  MAX_STEPS_RST = 8'd60;
  localparam logic [DUTY_W-1:0]   DUTY_MIN_RST  = 16'd700;
  localparam logic [DSTEP_W-1:0]  DUTY_STEP_RST = 8'd12;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_PRESS   = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  typedef enum logic {
    RES_REQUEST = 1'b0,
    RES_SERVO   = 1'b1
  } res_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET    = 3'd0,
    REG_SPAN      = 3'd1,
    REG_MAX_STEPS = 3'd2,
    REG_DUTY_MIN  = 3'd3,
    REG_DUTY_STEP = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_LOAD,
    ST_OFFSET,
    ST_SCALE_LOAD,
    ST_SCALE_DIV,
    ST_CLAMP,
    ST_MULT,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic      acc_en;
    logic      acc_clr;
    logic      avg_load;
    logic      div_step;
    logic      offset_calc;
    logic      scale_load;
    logic      clamp;
    logic      mult;
    logic      duty_sum;
    logic      out_load;
    res_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic group_done;
  } dp_stat_t;

endpackage

// ===== rtl/sensor_to_dual_servo_duty.sv =====
// Sensor to dual servo duty generator.
// The input stream carries one event per word: in_tuser holds the kind (tick,
// converter sample, button press, button release) and in_tdata the sample.
// A press toggles run mode once armed; while running, a tick yields a conversion
// request word and every AVERAGE_COUNT samples yield a servo setting word.
// On the output stream out_tuser is 0 for a request and 1 for a servo
// setting; out_tdata carries the angle step and both duty compare values.
// A request passes through the emit state into the output register once its
// tick is accepted. A servo setting passes from the completing sample through
// the average, offset, scale load, divide, clamp, multiply, sum and emit
// states; the divider scaling by span retires two quotient bits per cycle.
// Other events keep in_tready high; it drops while a result is produced.
// The output word sits in a register, so the next event is taken while it
// waits; if the receiver stalls with a new result ready, the block holds
// that result and stops taking events until the register frees.
// Reset (rst_n low at a clock edge) stops run mode, disarms the button,
// clears the running sum and restores the register defaults.
module sensor_to_dual_servo_duty #(
  parameter int AVERAGE_COUNT = 5,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,  // sample
  input  logic [stdsd_pkg::KIND_W-1:0]           in_tuser,  // kind
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // angle[7:0], duty_first[23:8], duty_second[39:24]
  output logic [stdsd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tuser, // result_kind
  input  logic                                   cfg_we,
  input  logic [stdsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stdsd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  stdsd_pkg::dp_cmd_t  cmd;
  stdsd_pkg::dp_stat_t stat;

  logic                             res_kind;
  logic [stdsd_pkg::ANGLE_W-1:0]    angle;
  logic [stdsd_pkg::DUTY_W-1:0]     duty_first;
  logic [stdsd_pkg::DUTY_W-1:0]     duty_second;

  stdsd_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (stdsd_pkg::kind_t'(in_tuser)),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  stdsd_dp #(
    .AVERAGE_COUNT (AVERAGE_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .sample          (in_tdata[SAMPLE_BITS-1:0]),
    .cmd             (cmd),
    .stat            (stat),
    .out_kind        (res_kind),
    .out_angle       (angle),
    .out_duty_first  (duty_first),
    .out_duty_second (duty_second)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {duty_second, duty_first, angle};

endmodule

// ===== rtl/stdsd_dp.sv =====
module stdsd_dp #(
  parameter int AVERAGE_COUNT = 5,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [stdsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stdsd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]                 sample,
  input  stdsd_pkg::dp_cmd_t                     cmd,
  output stdsd_pkg::dp_stat_t                    stat,
  output logic                                   out_kind,
  output logic [stdsd_pkg::ANGLE_W-1:0]          out_angle,
  output logic [stdsd_pkg::DUTY_W-1:0]           out_duty_first,
  output logic [stdsd_pkg::DUTY_W-1:0]           out_duty_second
);

  localparam int SUM_W  = $clog2(AVERAGE_COUNT * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int CNT_W  = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;
  localparam int PROD_W = SAMPLE_BITS + stdsd_pkg::STEPS_W;
  localparam int QW     = 2 * ((PROD_W + 1) / 2);
  localparam int DIVW   = stdsd_pkg::SPAN_W;
  localparam int REM_W  = DIVW + 1;
  localparam int CMP_W  = (SAMPLE_BITS > stdsd_pkg::OFFSET_W) ? SAMPLE_BITS
                                                              : stdsd_pkg::OFFSET_W;
  localparam int AW     = stdsd_pkg::ANGLE_W;
  localparam int DW     = stdsd_pkg::DUTY_W;

  // The group average is a multiply by a rounded-up reciprocal; with this
  // shift it is exact for every sum the accumulator can hold.
  localparam int RECIP_SH = SUM_W + $clog2(AVERAGE_COUNT);
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PRODA_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((1 << RECIP_SH) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

  logic [stdsd_pkg::OFFSET_W-1:0] offset_r;
  logic [stdsd_pkg::SPAN_W-1:0]   span_r;
  logic [stdsd_pkg::STEPS_W-1:0]  max_steps_r;
  logic [DW-1:0]                  duty_min_r;
  logic [stdsd_pkg::DSTEP_W-1:0]  duty_step_r;

  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [QW-1:0]          dvd_r, dvd_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [DIVW-1:0]        dvs_r, dvs_nxt;
  logic [SAMPLE_BITS-1:0] d_r, d_nxt;
  logic [AW-1:0]          angle_r, angle_nxt;
  logic [DW-1:0]          prod1_r, prod2_r;
  logic [DW-1:0]          duty1_r, duty2_r;
  logic                   out_kind_r;
  logic [AW-1:0]          out_angle_r;
  logic [DW-1:0]          out_duty1_r, out_duty2_r;

  logic [AW-1:0]          top;
  logic [PRODA_W-1:0]     avg_prod;
  logic [CMP_W-1:0]       avg_ext, off_ext;
  logic [DW:0]            sum1, sum2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= stdsd_pkg::OFFSET_RST;
      span_r      <= stdsd_pkg::SPAN_RST;
      max_steps_r <= stdsd_pkg::MAX_STEPS_RST;
      duty_min_r  <= stdsd_pkg::DUTY_MIN_RST;
      duty_step_r <= stdsd_pkg::DUTY_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stdsd_pkg::REG_OFFSET:    offset_r    <= cfg_wdata[stdsd_pkg::OFFSET_W-1:0];
        stdsd_pkg::REG_SPAN:      span_r      <= cfg_wdata[stdsd_pkg::SPAN_W-1:0];
        stdsd_pkg::REG_MAX_STEPS: max_steps_r <= cfg_wdata[stdsd_pkg::STEPS_W-1:0];
        stdsd_pkg::REG_DUTY_MIN:  duty_min_r  <= cfg_wdata[DW-1:0];
        stdsd_pkg::REG_DUTY_STEP: duty_step_r <= cfg_wdata[stdsd_pkg::DSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.group_done = (cnt_r == CNT_W'(AVERAGE_COUNT - 1));
  assign top = (max_steps_r == '0) ? '0 : max_steps_r - AW'(1);

  // Sample accumulator.
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cmd.acc_clr || cmd.avg_load) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.acc_en) begin
      sum_nxt = sum_r + SUM_W'(sample);
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign avg_prod = PRODA_W'(sum_r) * PRODA_W'(RECIP_M);

  always_comb begin
    avg_nxt = avg_r;
    if (cmd.avg_load) begin
      avg_nxt = avg_prod[RECIP_SH +: SAMPLE_BITS];
    end
  end

  // Restoring divider for the scaling by span, two quotient bits per step.
  // The quotient shifts into the low end of the dividend register.
  always_comb begin
    logic [QW-1:0]    q;
    logic [REM_W-1:0] r;
    q = dvd_r;
    r = rem_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (cmd.scale_load) begin
      dvd_nxt = QW'(d_r * max_steps_r);
      rem_nxt = '0;
      dvs_nxt = span_r;
    end else if (cmd.div_step) begin
      for (int k = 0; k < 2; k++) begin
        r = {r[REM_W-2:0], q[QW-1]};
        q = {q[QW-2:0], 1'b0};
        if (r >= {1'b0, dvs_r}) begin
          r    = r - {1'b0, dvs_r};
          q[0] = 1'b1;
        end
      end
      dvd_nxt = q;
      rem_nxt = r;
    end
  end

  assign avg_ext = CMP_W'(avg_r);
  assign off_ext = CMP_W'(offset_r);

  always_comb begin
    d_nxt = d_r;
    if (cmd.offset_calc) begin
      d_nxt = (avg_ext > off_ext) ? SAMPLE_BITS'(avg_ext - off_ext) : '0;
    end
  end

  // A zero span maps any positive deviation to the last step.
  always_comb begin
    angle_nxt = angle_r;
    if (cmd.clamp) begin
      if (span_r == '0) begin
        angle_nxt = (d_r != '0) ? top : '0;
      end else if (dvd_r > QW'(top)) begin
        angle_nxt = top;
      end else begin
        angle_nxt = dvd_r[AW-1:0];
      end
    end
  end

  assign sum1 = (DW + 1)'(duty_min_r) + (DW + 1)'(prod1_r);
  assign sum2 = (DW + 1)'(duty_min_r) + (DW + 1)'(prod2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r   <= avg_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    d_r     <= d_nxt;
    angle_r <= angle_nxt;
    if (cmd.mult) begin
      prod1_r <= (DW'(angle_r) + DW'(1)) * DW'(duty_step_r);
      prod2_r <= (DW'(top - angle_r) + DW'(1)) * DW'(duty_step_r);
    end
    if (cmd.duty_sum) begin
      duty1_r <= sum1[DW] ? {DW{1'b1}} : sum1[DW-1:0];
      duty2_r <= sum2[DW] ? {DW{1'b1}} : sum2[DW-1:0];
    end
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      if (cmd.out_kind == stdsd_pkg::RES_REQUEST) begin
        out_angle_r <= '0;
        out_duty1_r <= '0;
        out_duty2_r <= '0;
      end else begin
        out_angle_r <= angle_r;
        out_duty1_r <= duty1_r;
        out_duty2_r <= duty2_r;
      end
    end
  end

  assign out_kind        = out_kind_r;
  assign out_angle       = out_angle_r;
  assign out_duty_first  = out_duty1_r;
  assign out_duty_second = out_duty2_r;

endmodule

// ===== rtl/stdsd_ctrl.sv =====
module stdsd_ctrl #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  stdsd_pkg::kind_t    in_kind,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output stdsd_pkg::dp_cmd_t  cmd,
  input  stdsd_pkg::dp_stat_t stat
);

  localparam int DIV_STEPS = (SAMPLE_BITS + stdsd_pkg::STEPS_W + 1) / 2;
  localparam int IT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  stdsd_pkg::state_t    state_r, state_nxt;
  logic                 running_r, running_nxt;
  logic                 armed_r, armed_nxt;
  logic                 await_r, await_nxt;
  logic                 out_valid_r, out_valid_nxt;
  stdsd_pkg::res_kind_t emit_kind_r, emit_kind_nxt;
  logic [IT_W-1:0]      iter_r, iter_nxt;

  logic in_acc;
  logic out_free;
  logic div_last;

  assign in_ready  = (state_r == stdsd_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign div_last  = (iter_r == IT_W'(DIV_STEPS - 1));
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stdsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            stdsd_pkg::KIND_TICK:
              if (running_r) state_nxt = stdsd_pkg::ST_EMIT;
            stdsd_pkg::KIND_SAMPLE:
              if (running_r && stat.group_done) state_nxt = stdsd_pkg::ST_AVG_LOAD;
            default: ;
          endcase
        end
      end
      stdsd_pkg::ST_AVG_LOAD:   state_nxt = stdsd_pkg::ST_OFFSET;
      stdsd_pkg::ST_OFFSET:     state_nxt = stdsd_pkg::ST_SCALE_LOAD;
      stdsd_pkg::ST_SCALE_LOAD: state_nxt = stdsd_pkg::ST_SCALE_DIV;
      stdsd_pkg::ST_SCALE_DIV:  if (div_last) state_nxt = stdsd_pkg::ST_CLAMP;
      stdsd_pkg::ST_CLAMP:      state_nxt = stdsd_pkg::ST_MULT;
      stdsd_pkg::ST_MULT:       state_nxt = stdsd_pkg::ST_SUM;
      stdsd_pkg::ST_SUM:        state_nxt = stdsd_pkg::ST_EMIT;
      stdsd_pkg::ST_EMIT:       if (out_free) state_nxt = stdsd_pkg::ST_IDLE;
      default:                  state_nxt = stdsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.out_kind  = emit_kind_r;
    running_nxt   = running_r;
    armed_nxt     = armed_r;
    await_nxt     = await_r;
    emit_kind_nxt = emit_kind_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      stdsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            stdsd_pkg::KIND_TICK: begin
              armed_nxt     = 1'b1;
              emit_kind_nxt = stdsd_pkg::RES_REQUEST;
            end
            stdsd_pkg::KIND_SAMPLE: begin
              cmd.acc_en    = running_r;
              emit_kind_nxt = stdsd_pkg::RES_SERVO;
            end
            stdsd_pkg::KIND_PRESS: begin
              if (armed_r && !await_r) begin
                running_nxt = !running_r;
                cmd.acc_clr = running_r;
                await_nxt   = 1'b1;
                armed_nxt   = 1'b0;
              end
            end
            stdsd_pkg::KIND_RELEASE: begin
              if (armed_r && await_r) begin
                await_nxt = 1'b0;
                armed_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      stdsd_pkg::ST_AVG_LOAD: cmd.avg_load = 1'b1;
      stdsd_pkg::ST_SCALE_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + IT_W'(1);
      end
      stdsd_pkg::ST_OFFSET:  cmd.offset_calc = 1'b1;
      stdsd_pkg::ST_SCALE_LOAD: begin
        cmd.scale_load = 1'b1;
        iter_nxt       = '0;
      end
      stdsd_pkg::ST_CLAMP:   cmd.clamp    = 1'b1;
      stdsd_pkg::ST_MULT:    cmd.mult     = 1'b1;
      stdsd_pkg::ST_SUM:     cmd.duty_sum = 1'b1;
      stdsd_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stdsd_pkg::ST_IDLE;
      running_r   <= 1'b0;
      armed_r     <= 1'b0;
      await_r     <= 1'b0;
      out_valid_r <= 1'b0;
      emit_kind_r <= stdsd_pkg::RES_REQUEST;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      armed_r     <= armed_nxt;
      await_r     <= await_nxt;
      out_valid_r <= out_valid_nxt;
      emit_kind_r <= emit_kind_nxt;
      iter_r      <= iter_nxt;
    end
  end

endmodule
